// ----- rtl/core/dtsc_pkg.sv -----
package dtsc_pkg;

  // fixed table shape, settled by the field widths of a request
  localparam int SLOT_COUNT  = 4;
  localparam int FILE_COUNT  = 4;
  localparam int MAP_SLOTS   = 4;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int FILE_IDX_W  = 2;
  localparam int RESULT_CAP  = 64;
  localparam int STORE_BYTES = 64;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_KINDS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MAP = 2'd1;

  localparam logic [7:0]  KINDS_RESET = 8'd9;
  localparam logic [11:0] MAP_RESET   = 12'd352;

  // file kinds; code 3 behaves as no file
  localparam logic [1:0] KIND_CONSOLE = 2'd1;
  localparam logic [1:0] KIND_MEMORY  = 2'd2;

  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_READ  = 3'd1,
    FUNC_DUP   = 3'd2,
    FUNC_SEEK  = 3'd3,
    FUNC_TELL  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RD_CHECK,
    ST_RD_EMIT
  } dtsc_state_e;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] descriptor;
    logic [2:0] target_descriptor;
    logic [6:0] position;
    logic [7:0] data_byte;
    logic [6:0] read_count;
  } req_t;

  typedef struct packed {
    logic       refused;
    logic [6:0] answer;
    logic       console_valid;
    logic [7:0] console_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last;
  } rsp_t;

  // compare results of the cursor unit
  typedef struct packed {
    logic lt_len;
    logic lt_store;
  } cur_flags_t;

  typedef logic [SLOT_COUNT-1:0][2:0] map_t;

  // descriptor map as loaded from the initial map register
  function automatic map_t load_map(input logic [11:0] v);
    map_t m;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      m[s] = 3'b000;
      if (s < MAP_SLOTS) begin
        m[s] = v[3*s +: 3];
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/dtsc_if.sv -----
// request channel
interface dtsc_req_if;
  logic               valid;
  logic               ready;
  dtsc_pkg::req_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// result channel
interface dtsc_rsp_if;
  logic               valid;
  logic               ready;
  dtsc_pkg::rsp_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// register write channel
interface dtsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dtsc_pkg::CFG_IDX_W-1:0]   index;
  logic [11:0]                      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/dtsc_ram.sv -----
module dtsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dtsc_cursor_unit.sv -----
module dtsc_cursor_unit #(
  parameter int STORE_BYTES = dtsc_pkg::STORE_BYTES
) (
  input  logic [$clog2(STORE_BYTES+1)-1:0] cur_i,
  input  logic [$clog2(STORE_BYTES+1)-1:0] len_i,
  output logic [$clog2(STORE_BYTES+1)-1:0] inc_o,
  output dtsc_pkg::cur_flags_t             flags_o
);
  import dtsc_pkg::*;

  localparam int CurW = $clog2(STORE_BYTES+1);

  // advance and bound checks shared by writes and every read step
  assign inc_o            = cur_i + CurW'(1);
  assign flags_o.lt_len   = cur_i < len_i;
  assign flags_o.lt_store = cur_i < CurW'(STORE_BYTES);

endmodule

// ----- rtl/core/descriptor_table_with_shared_cursors.sv -----
// channel  dir  handshake      payload
// req_i    in   valid/ready    func, descriptor, target_descriptor, position, data_byte,
//                              read_count
// rsp_o    out  valid/ready    refused, answer, console_valid/byte, read_valid/byte, last
// cfg_i    in   valid/ready    index (0 file_kinds, 1 initial_map), data; always ready
//
// write, duplicate, seek and tell: a request passes latch, then decode
// read of n bytes: latch, decode, first store read, then one byte a cycle while results are taken
// after reset a clearing pass zeroes every byte of the store, no request taken
// a held result stalls the sequencer; the next request is taken once it is registered
module descriptor_table_with_shared_cursors #(
  parameter int STORE_BYTES = dtsc_pkg::STORE_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtsc_req_if.sink   req_i,
  dtsc_rsp_if.source rsp_o,
  dtsc_cfg_if.sink   cfg_i
);
  import dtsc_pkg::*;

  localparam int CurW    = $clog2(STORE_BYTES+1);
  localparam int AddrW   = $clog2(STORE_BYTES);
  localparam int ReadCap = (STORE_BYTES < RESULT_CAP) ? STORE_BYTES : RESULT_CAP;

  dtsc_state_e           state_q, state_d;
  req_t                  req_q;
  rsp_t                  rsp_q, rsp_new;
  logic                  out_valid_q;
  map_t                  map_q;
  logic [7:0]            kinds_q;
  logic [CurW-1:0]       cursors_q [FILE_COUNT];
  logic [CurW-1:0]       wlen_q;
  logic [6:0]            cnt_q, want_q;
  logic [AddrW-1:0]      clr_q;

  logic                  req_fire, cfg_fire, out_free, clr_last;
  logic                  slot_ok, found, is_mem, is_con, target_ok, pos_ok, rd_go, more;
  logic [2:0]            entry;
  logic [FILE_IDX_W-1:0] fidx;
  logic [1:0]            kind;
  logic [CurW-1:0]       cur, cur_inc, cur_new, wlen_new;
  logic [6:0]            want_calc;
  cur_flags_t            flags;

  logic                  emit, ram_we, ram_re, cur_we, wlen_we, map_we, rd_start, cnt_step;
  logic [AddrW-1:0]      ram_waddr;
  logic [7:0]            ram_wdata, ram_rdata;

  assign req_fire  = req_i.valid && req_i.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign clr_last  = clr_q == AddrW'(STORE_BYTES - 1);

  assign req_i.ready   = state_q == ST_IDLE;
  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

  // slot lookup and file attributes of the latched request
  assign slot_ok   = int'(req_q.descriptor) < SLOT_COUNT;
  assign entry     = map_q[req_q.descriptor[SLOT_W-1:0]];
  assign fidx      = entry[FILE_IDX_W-1:0];
  assign found     = slot_ok && entry[2] && (int'(fidx) < FILE_COUNT);
  assign kind      = kinds_q[{fidx, 1'b0} +: 2];
  assign is_mem    = kind == KIND_MEMORY;
  assign is_con    = kind == KIND_CONSOLE;
  assign cur       = cursors_q[fidx];
  assign target_ok = int'(req_q.target_descriptor) < SLOT_COUNT;
  assign pos_ok    = int'(req_q.position) <= STORE_BYTES;
  assign rd_go     = found && (req_q.func == FUNC_READ) && is_mem;
  assign want_calc = (int'(req_q.read_count) > ReadCap) ? 7'(ReadCap) : req_q.read_count;

  dtsc_cursor_unit #(
    .STORE_BYTES(STORE_BYTES)
  ) u_cursor (
    .cur_i   (cur),
    .len_i   (wlen_q),
    .inc_o   (cur_inc),
    .flags_o (flags)
  );

  assign more = (cnt_q < want_q) && flags.lt_len && flags.lt_store;

  dtsc_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_fire) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (rd_go) state_d = ST_RD_CHECK;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_RD_CHECK: begin
        if (more) state_d = ST_RD_EMIT;
        else if (out_free) state_d = ST_IDLE;
      end
      ST_RD_EMIT: begin
        if (out_free && !more) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer actions and result assembly
  always_comb begin
    emit      = 1'b0;
    rsp_new   = '0;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = 8'd0;
    ram_re    = 1'b0;
    cur_we    = 1'b0;
    cur_new   = cur_inc;
    wlen_we   = 1'b0;
    wlen_new  = cur_inc;
    map_we    = 1'b0;
    rd_start  = 1'b0;
    cnt_step  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
      end
      ST_DECODE: begin
        rd_start     = rd_go;
        rsp_new.last = 1'b1;
        if (!rd_go && out_free) begin
          emit = 1'b1;
          if (!found) begin
            rsp_new.refused = 1'b1;
          end else begin
            unique case (req_q.func)
              FUNC_WRITE: begin
                if (is_con) begin
                  rsp_new.answer        = 7'd1;
                  rsp_new.console_valid = 1'b1;
                  rsp_new.console_byte  = req_q.data_byte;
                end else if (is_mem) begin
                  // store at the cursor unless it sits at the end
                  if (flags.lt_store) begin
                    ram_we         = 1'b1;
                    ram_waddr      = cur[AddrW-1:0];
                    ram_wdata      = req_q.data_byte;
                    cur_we         = 1'b1;
                    rsp_new.answer = 7'd1;
                    wlen_we        = !flags.lt_len;
                  end else begin
                    wlen_new = cur;
                    wlen_we  = wlen_q != cur;
                  end
                end else begin
                  rsp_new.refused = 1'b1;
                end
              end
              FUNC_DUP: begin
                if (target_ok) begin
                  map_we         = 1'b1;
                  rsp_new.answer = 7'(req_q.target_descriptor);
                end else begin
                  rsp_new.refused = 1'b1;
                end
              end
              FUNC_SEEK: begin
                if (is_mem && pos_ok) begin
                  cur_we         = 1'b1;
                  cur_new        = CurW'(req_q.position);
                  rsp_new.answer = req_q.position;
                end else begin
                  rsp_new.refused = 1'b1;
                end
              end
              FUNC_TELL: begin
                rsp_new.answer = 7'(cur);
              end
              default: begin
                // read on a file that is not memory, or an unknown operation
                rsp_new.refused = 1'b1;
              end
            endcase
          end
        end
      end
      ST_RD_CHECK: begin
        if (more) begin
          ram_re   = 1'b1;
          cur_we   = 1'b1;
          cnt_step = 1'b1;
        end else if (out_free) begin
          // nothing to take
          emit         = 1'b1;
          rsp_new.last = 1'b1;
        end
      end
      ST_RD_EMIT: begin
        if (out_free) begin
          emit               = 1'b1;
          rsp_new.read_valid = 1'b1;
          rsp_new.read_byte  = ram_rdata;
          rsp_new.last       = !more;
          rsp_new.answer     = more ? 7'd0 : cnt_q;
          if (more) begin
            ram_re   = 1'b1;
            cur_we   = 1'b1;
            cnt_step = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control state and tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      kinds_q     <= KINDS_RESET;
      map_q       <= load_map(MAP_RESET);
      wlen_q      <= '0;
      cnt_q       <= '0;
      want_q      <= '0;
      for (int f = 0; f < FILE_COUNT; f++) begin
        cursors_q[f] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AddrW'(1);
      if (cfg_fire && cfg_i.index == CFG_FILE_KINDS) kinds_q <= cfg_i.data[7:0];
      if (cfg_fire && cfg_i.index == CFG_INITIAL_MAP) begin
        map_q <= load_map(cfg_i.data);
      end else if (map_we) begin
        map_q[req_q.target_descriptor[SLOT_W-1:0]] <= entry;
      end
      if (cur_we) cursors_q[fidx] <= cur_new;
      if (wlen_we) wlen_q <= wlen_new;
      if (rd_start) begin
        cnt_q  <= '0;
        want_q <= want_calc;
      end else if (cnt_step) begin
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  // request and result payloads
  always_ff @(posedge clk_i) begin
    if (req_fire) req_q <= req_i.payload;
    if (emit) rsp_q <= rsp_new;
  end

  // written length never passes the end of the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wlen_q) <= STORE_BYTES)
    else $error("written length beyond store");

  // no request is taken while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !req_fire)
    else $error("request taken during clearing pass");

  // every store read is followed by a byte step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> state_q == ST_RD_EMIT)
    else $error("store read without a byte step");

  // the store is never written in the middle of a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_CHECK || state_q == ST_RD_EMIT) |-> !ram_we)
    else $error("store write during read");

  // byte count stays within the requested amount
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD_EMIT |-> (cnt_q <= want_q && cnt_q != 7'd0))
    else $error("read count out of range");

endmodule
